// ----- sv/nsos_pkg.sv -----
// Shared types, sizes and codes for the nearest-sample outlier score block.
`timescale 1ns / 1ps
`default_nettype none

package nsos_pkg;

  // Store sizes
  localparam int MAX_POINTS  = 1024;
  localparam int MAX_DIMS    = 8;
  localparam int MAX_SAMPLES = 256;

  // Index and counter widths derived from the store sizes
  localparam int PT_W      = $clog2(MAX_POINTS);
  localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SLOT_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CADDR_W   = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int ND_W      = $clog2(MAX_DIMS + 1);
  localparam int NS_W      = $clog2(MAX_SAMPLES + 1);

  // Arithmetic widths: Q12.12 coordinates, exact squared-distance sums
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + $clog2(MAX_DIMS + 1);
  localparam int SQ_W    = SUM_W + (SUM_W % 2);
  localparam int ROOT_W  = SQ_W / 2;
  localparam int SCORE_W = 26;

  // Configuration register widths and indexes
  localparam int PCOUNT_W   = 11;
  localparam int DUSED_W    = 4;
  localparam int SCOUNT_W   = 9;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_USED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;
  localparam logic [DUSED_W-1:0]  DUSED_RESET  = 4'd5;
  localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 9'd256;

  // Command word modes
  localparam logic [1:0] MODE_LOAD_COORD  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_QUERY       = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  point_index;
    logic [2:0]  dim_index;
    logic signed [23:0] coord_value;
    logic [7:0]  sample_slot;
    logic [9:0]  sample_point;
  } item_t;

  typedef struct packed {
    logic [25:0] score;
    logic [9:0]  query_point;
    logic        error;
  } result_t;

  // Tag that travels with each coordinate read into the distance unit
  typedef struct packed {
    logic                 valid;
    logic                 load;   // word is a query coordinate to cache
    logic                 first;  // first dimension of a sample
    logic                 last;   // last dimension of a sample
    logic [DIM_IDX_W-1:0] dim;
  } mac_tag_t;

endpackage

`default_nettype wire

// ----- sv/nearest_sample_outlier_score.sv -----
// Top level: command decode, point and sample stores, query sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Nearest-sample outlier score. Load words (coordinate or sample index) are
// written in the cycle they are taken and never raise busy. An in-range query
// word raises busy until its result: the sequencer first reads the queried
// point's dims_used coordinates, then for each of the sample_count slots reads
// the slot index and, unless the slot names the queried point, reads one
// coordinate per dimension through the single read port of the coordinate
// memory into a shared difference/square/accumulate unit. The sequencer then
// waits for that unit's pipeline to drain, a bit-serial square root produces
// the root, and the root is handed to the result register.
// A query naming a point at or beyond point_count returns error with score 0
// on the next cycle. Each result is shown on result for the single cycle in
// which done is high; the receiver cannot stall it, so capture it then.
// Configuration writes are taken at once and must only happen while idle.
module nearest_sample_outlier_score
  import nsos_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire item_t                 item,
  output logic                       busy,
  output logic                       done,
  output result_t                    result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_QLD, S_SCHK, S_CRD, S_DRAIN, S_SQRT
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [PCOUNT_W-1:0] point_count;
  logic [DUSED_W-1:0]  dims_used;
  logic [SCOUNT_W-1:0] sample_count;
  logic [ND_W-1:0]     nd;
  logic [NS_W-1:0]     ns;

  // Stores
  logic [COORD_W-1:0] cmem [MAX_POINTS * MAX_DIMS];
  logic [PT_W-1:0]    smem [MAX_SAMPLES];
  logic [COORD_W-1:0] crdata;
  logic [PT_W-1:0]    srdata;
  logic [CADDR_W-1:0] craddr;
  logic [SLOT_W-1:0]  sraddr;

  // Sequencer registers
  logic [NS_W-1:0]  s, s_next;
  logic [ND_W-1:0]  j, j_next;
  logic [9:0]       qpt;
  logic [PT_W-1:0]  other;
  mac_tag_t         tag_issue, tag_q;

  // Handshake and decode
  logic accept, query_acc, query_err, cwe, swe, sq_start, sq_done, mac_busy;
  logic [SUM_W-1:0]  best;
  logic [ROOT_W-1:0] root;

  assign accept    = start && !busy;
  assign query_acc = accept && (item.mode == MODE_QUERY);
  assign query_err = (32'(item.point_index) >= 32'(point_count)) ||
                     (32'(item.point_index) >= MAX_POINTS);
  assign cwe = accept && (item.mode == MODE_LOAD_COORD) &&
               (32'(item.point_index) < MAX_POINTS) && (32'(item.dim_index) < MAX_DIMS);
  assign swe = accept && (item.mode == MODE_LOAD_SAMPLE) &&
               (32'(item.sample_slot) < MAX_SAMPLES) && (32'(item.sample_point) < MAX_POINTS);
  assign busy = (state != S_IDLE);

  // Saturate dimension and sample counts to the store sizes
  assign nd = (32'(dims_used) > MAX_DIMS) ? ND_W'(MAX_DIMS) : ND_W'(dims_used);
  assign ns = (32'(sample_count) > MAX_SAMPLES) ? NS_W'(MAX_SAMPLES) : NS_W'(sample_count);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= PCOUNT_RESET;
      dims_used    <= DUSED_RESET;
      sample_count <= SCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT:  point_count  <= PCOUNT_W'(cfg_data);
        CFG_DIMS_USED:    dims_used    <= DUSED_W'(cfg_data);
        CFG_SAMPLE_COUNT: sample_count <= SCOUNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Coordinate store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[CADDR_W'(item.point_index) * CADDR_W'(MAX_DIMS) + CADDR_W'(item.dim_index)]
        <= item.coord_value;
    end
    crdata <= cmem[craddr];
  end

  // Sample index store: one write, one registered read
  always_ff @(posedge clk) begin
    if (swe) begin
      smem[SLOT_W'(item.sample_slot)] <= PT_W'(item.sample_point);
    end
    srdata <= smem[sraddr];
  end

  assign sraddr = s_next[SLOT_W-1:0];

  // Sequence one query: cache query point, walk samples, drain, square root
  always_comb begin
    state_next = state;
    s_next     = s;
    j_next     = j;
    sq_start   = 1'b0;
    tag_issue  = '0;
    craddr     = CADDR_W'(other) * CADDR_W'(MAX_DIMS) + CADDR_W'(j[DIM_IDX_W-1:0]);
    case (state)
      S_IDLE: begin
        if (query_acc && !query_err) begin
          j_next     = '0;
          state_next = ((nd == '0) || (ns == '0)) ? S_DRAIN : S_QLD;
        end
      end
      S_QLD: begin
        craddr          = CADDR_W'(qpt) * CADDR_W'(MAX_DIMS) + CADDR_W'(j[DIM_IDX_W-1:0]);
        tag_issue.valid = 1'b1;
        tag_issue.load  = 1'b1;
        tag_issue.dim   = j[DIM_IDX_W-1:0];
        if (j == nd - ND_W'(1)) begin
          j_next     = '0;
          s_next     = '0;
          state_next = S_SCHK;
        end else begin
          j_next = j + ND_W'(1);
        end
      end
      S_SCHK: begin
        if (32'(srdata) == 32'(qpt)) begin
          // Skip a slot that names the queried point
          if (s == ns - NS_W'(1)) begin
            state_next = S_DRAIN;
          end else begin
            s_next = s + NS_W'(1);
          end
        end else begin
          j_next     = '0;
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        tag_issue.valid = 1'b1;
        tag_issue.first = (j == '0);
        tag_issue.last  = (j == nd - ND_W'(1));
        tag_issue.dim   = j[DIM_IDX_W-1:0];
        if (j == nd - ND_W'(1)) begin
          j_next = '0;
          if (s == ns - NS_W'(1)) begin
            state_next = S_DRAIN;
          end else begin
            s_next     = s + NS_W'(1);
            state_next = S_SCHK;
          end
        end else begin
          j_next = j + ND_W'(1);
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          sq_start   = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state, counters and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      tag_q <= '0;
    end else begin
      state <= state_next;
      tag_q <= tag_issue;
      done  <= 1'b0;
      if (query_acc) begin
        qpt <= item.point_index;
        if (query_err) begin
          result.score       <= '0;
          result.query_point <= item.point_index;
          result.error       <= 1'b1;
          done               <= 1'b1;
        end
      end
      if ((state == S_SCHK) && (state_next == S_CRD)) begin
        other <= srdata;
      end
      if ((state == S_SQRT) && sq_done) begin
        result.score       <= SCORE_W'(root);
        result.query_point <= qpt;
        result.error       <= 1'b0;
        done               <= 1'b1;
      end
    end
    s <= s_next;
    j <= j_next;
  end

  nsos_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .tag   (tag_q),
    .coord ($signed(crdata)),
    .clear (query_acc),
    .best  (best),
    .busy  (mac_busy)
  );

  nsos_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (SQ_W'(best)),
    .done  (sq_done),
    .root  (root)
  );

`ifndef ASSERT_OFF
  // The square root starts only once the distance pipeline has drained
  a_sqrt_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> !mac_busy)
    else $error("square root running while distance unit busy");

  // An error result always carries a zero score
  a_error_score_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> (result.score == '0))
    else $error("error result with nonzero score");

  // An out-of-range query answers on the next cycle with error set
  a_range_error: assert property (@(posedge clk) disable iff (rst)
    (query_acc && query_err) |=> (done && result.error && (state == S_IDLE)))
    else $error("out-of-range query not reported");

  // A result word never appears while a query is still in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while busy");
`endif

endmodule

`default_nettype wire

// ----- sv/nsos_mac.sv -----
// Shared distance unit: difference, square, accumulate and keep the smallest positive sum.
`timescale 1ns / 1ps
`default_nettype none

module nsos_mac
  import nsos_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_tag_t                  tag,
  input  wire logic signed [COORD_W-1:0] coord,
  input  wire logic                      clear,
  output logic [SUM_W-1:0]               best,
  output logic                           busy
);

  logic signed [COORD_W-1:0] qcoord [MAX_DIMS];
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag_a;
  logic                      a_valid, a_first, a_last;
  logic [PROD_W-1:0]         prod_b;
  logic                      b_valid, b_first, b_last;
  logic [SUM_W-1:0]          acc;
  logic                      acc_done;

  // Signed difference against the cached query coordinate
  assign diff = DIFF_W'(qcoord[tag.dim]) - DIFF_W'(coord);

  // Cache the query point's coordinates
  always_ff @(posedge clk) begin
    if (tag.valid && tag.load) begin
      qcoord[tag.dim] <= coord;
    end
  end

  // Stage A: magnitude of the difference
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= tag.valid && !tag.load;
    end
    a_first <= tag.first;
    a_last  <= tag.last;
    mag_a   <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // Stage B: square
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_first <= a_first;
    b_last  <= a_last;
    prod_b  <= mag_a * mag_a;
  end

  // Stage C: accumulate over dimensions of one sample
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else begin
      acc_done <= b_valid && b_last;
    end
    if (b_valid) begin
      acc <= (b_first ? '0 : acc) + SUM_W'(prod_b);
    end
  end

  // Stage D: keep the smallest positive sum
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best <= '0;
    end else if (acc_done && (acc != '0) && ((best == '0) || (acc < best))) begin
      best <= acc;
    end
  end

  assign busy = tag.valid || a_valid || b_valid || acc_done;

endmodule

`default_nettype wire

// ----- sv/nsos_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module nsos_isqrt
  import nsos_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   value,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_t;

  sq_state_t          state;
  logic [SQ_W-1:0]    rad;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [CNT_W-1:0]   cnt;

  // Bring down the next two radicand bits and form the trial subtrahend
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SQ_IDLE: begin
          if (start) begin
            rad   <= value;
            rem   <= '0;
            root  <= '0;
            cnt   <= CNT_W'(ROOT_W);
            state <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          rad <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= SQ_IDLE;
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
